FILE: sv/spsf_pkg.sv
// Shared types and constants for the safe-prime sieve filter.
// Holds field widths, stream packing widths, command codes, FSM codes and the table entry layout.
// No dependencies.
package spsf_pkg;

  // Field widths
  localparam int unsigned DATA_W = 64;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_W  = 11;

  // Stream packing widths (tdata in whole bytes)
  localparam int unsigned S_TDATA_W = 336;
  localparam int unsigned S_TUSER_W = CMD_W;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 1;

  // Default sizes
  localparam int unsigned ENTRY_DEPTH_DEF = 1024;
  localparam int unsigned ROW_COUNT_DEF   = 16;

  // Command codes carried on s_axis_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_ENTRY = 2'd0,
    CMD_WRITE_ROW   = 2'd1,
    CMD_TEST        = 2'd2
  } cmd_e;

  // Walk sequencer, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RD_ENT = 9'b000000010,
    ST_RD_ROW = 9'b000000100,
    ST_ADD    = 9'b000001000,
    ST_MUL0   = 9'b000010000,
    ST_MUL1   = 9'b000100000,
    ST_MUL2   = 9'b001000000,
    ST_CMP    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  // One divisor table entry
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] inverse;
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] offset_product;
  } entry_t;

endpackage

FILE: sv/safe_prime_sieve_filter.sv
// Safe-prime candidate sieve: divisor table, row residues and the test walk.
// Uses spsf_pkg for widths, command codes, FSM codes and the entry layout.
//
//  channel  | direction | tdata fields (low bit up)                          | tuser
//  s_axis   | in        | slot, row, inverse, threshold, offset_product,     | command
//           |           | residue, offset, zero pad                          |
//  m_axis   | out       | survives, zero pad                                 | was_test
//  cfg      | in        | entries_in_use (written when cfg_we_i is high)     | -
//
// Writes, unknown commands and zero-length walks are answered straight from idle; the result is registered.
// Any other test walks the entries in use (stopping at the first hit), taking each entry through these steps:
// read entry, read row residue, add, three 32x32 partial products on one multiplier, compare.
// rst_ni clears control state only; table and residue memories are undefined until written.
// s_axis_tready is low while a test walks or while a result waits that is not being taken.
module safe_prime_sieve_filter #(
  parameter int unsigned ENTRY_DEPTH = spsf_pkg::ENTRY_DEPTH_DEF,
  parameter int unsigned ROW_COUNT   = spsf_pkg::ROW_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: entries_in_use
  input  logic                            cfg_we_i,
  input  logic [spsf_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // slot[9:0] row[13:10] inverse[77:14] threshold[141:78] offset_product[205:142]
  // residue[269:206] offset[333:270]
  input  logic [spsf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [spsf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // survives[0]
  output logic [spsf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // was_test[0]
  output logic [spsf_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import spsf_pkg::*;

  localparam int unsigned EntAw   = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int unsigned RowAw   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned CntW    = $clog2(ENTRY_DEPTH + 1);
  localparam int unsigned SlotExW = (EntAw > SLOT_W) ? EntAw : SLOT_W;
  localparam int unsigned RowExW  = (RowAw > ROW_W) ? RowAw : ROW_W;

  // Input field unpacking
  logic [SLOT_W-1:0] in_slot;
  logic [ROW_W-1:0]  in_row;
  logic [DATA_W-1:0] in_inverse, in_threshold, in_offset_product, in_residue, in_offset;
  cmd_e              in_cmd;

  assign in_slot           = s_axis_tdata[9:0];
  assign in_row            = s_axis_tdata[13:10];
  assign in_inverse        = s_axis_tdata[77:14];
  assign in_threshold      = s_axis_tdata[141:78];
  assign in_offset_product = s_axis_tdata[205:142];
  assign in_residue        = s_axis_tdata[269:206];
  assign in_offset         = s_axis_tdata[333:270];
  assign in_cmd            = cmd_e'(s_axis_tuser[CMD_W-1:0]);

  // Registers
  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [DATA_W-1:0] offset_q, offset_d;
  logic [DATA_W-1:0] n_q, n_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              survive_q, survive_d;
  logic              out_valid_q, out_valid_d;
  logic              out_surv_q, out_surv_d;
  logic              out_test_q, out_test_d;
  logic              row_ok_q;

  // Memory ports
  entry_t            ent_mem [ENTRY_DEPTH];
  logic [DATA_W-1:0] row_mem [ROW_COUNT];
  entry_t            ent_rd_q;
  logic [DATA_W-1:0] row_rd_q;
  logic              ent_we, ent_re, row_we, row_re;
  logic [SlotExW-1:0] slot_ext;
  logic [RowExW-1:0]  in_row_ext, rd_row_ext;
  logic              rd_row_ok;
  entry_t            ent_wdata;

  logic in_fire, out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;

  // Write decode
  assign slot_ext   = SlotExW'(in_slot);
  assign in_row_ext = RowExW'(in_row);
  assign ent_we = in_fire && (in_cmd == CMD_WRITE_ENTRY) && (32'(in_slot) < 32'(ENTRY_DEPTH));
  assign row_we = in_fire && (in_cmd == CMD_WRITE_ROW) && (32'(in_row) < 32'(ROW_COUNT));
  assign ent_wdata = '{row: in_row, inverse: in_inverse, threshold: in_threshold,
                       offset_product: in_offset_product};

  // Row lookup for the entry just read; out-of-range rows read as zero
  assign rd_row_ext = RowExW'(ent_rd_q.row);
  assign rd_row_ok  = 32'(ent_rd_q.row) < 32'(ROW_COUNT);
  assign ent_re     = (state_q == ST_RD_ENT);
  assign row_re     = (state_q == ST_RD_ROW) && rd_row_ok;

  // Entry table memory
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[slot_ext[EntAw-1:0]] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[k_q[EntAw-1:0]];
    end
  end

  // Row residue memory
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[in_row_ext[RowAw-1:0]] <= in_residue;
    end
    if (row_re) begin
      row_rd_q <= row_mem[rd_row_ext[RowAw-1:0]];
    end
  end

  // Shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    unique case (state_q)
      ST_MUL1: begin
        mul_a = n_q[31:0];
        mul_b = ent_rd_q.inverse[63:32];
      end
      ST_MUL2: begin
        mul_a = n_q[63:32];
        mul_b = ent_rd_q.inverse[31:0];
      end
      default: begin
        mul_a = n_q[31:0];
        mul_b = ent_rd_q.inverse[31:0];
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Hit check on the finished product
  logic [DATA_W-1:0] p_minus;
  logic              hit;
  assign p_minus = acc_q - ent_rd_q.offset_product;
  assign hit = (acc_q < ent_rd_q.threshold) || (p_minus < ent_rd_q.threshold);

  // Saturated walk length from the register
  logic [CntW-1:0] count_sat;
  assign count_sat = (32'(cfg_q) > 32'(ENTRY_DEPTH)) ? CntW'(ENTRY_DEPTH) : CntW'(cfg_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    offset_d    = offset_q;
    n_d         = n_q;
    acc_d       = acc_q;
    survive_d   = survive_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_surv_d  = out_surv_q;
    out_test_d  = out_test_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_TEST) begin
            if (count_sat == '0) begin
              out_valid_d = 1'b1;
              out_surv_d  = 1'b1;
              out_test_d  = 1'b1;
            end else begin
              count_d  = count_sat;
              k_d      = '0;
              offset_d = in_offset;
              state_d  = ST_RD_ENT;
            end
          end else begin
            out_valid_d = 1'b1;
            out_surv_d  = 1'b0;
            out_test_d  = 1'b0;
          end
        end
      end
      ST_RD_ENT: state_d = ST_RD_ROW;
      ST_RD_ROW: state_d = ST_ADD;
      ST_ADD: begin
        n_d     = (row_ok_q ? row_rd_q : '0) + offset_q;
        state_d = ST_MUL0;
      end
      ST_MUL0: begin
        acc_d   = mul_p;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
        state_d      = ST_MUL2;
      end
      ST_MUL2: begin
        acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (hit) begin
          survive_d = 1'b0;
          state_d   = ST_DONE;
        end else if (k_q + 1'b1 == count_q) begin
          survive_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_RD_ENT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_surv_d  = survive_q;
          out_test_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
      row_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (state_q == ST_RD_ROW) begin
        row_ok_q <= rd_row_ok;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    k_q        <= k_d;
    offset_q   <= offset_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    survive_q  <= survive_d;
    out_surv_q <= out_surv_d;
    out_test_q <= out_test_d;
  end

  // Result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_surv_q};
  assign m_axis_tuser  = out_test_q;

endmodule
